### rtl/core/gtcw_pkg.sv
package gtcw_pkg;

   // request kinds
   localparam logic REQ_WRITE_CHAR = 1'b0;
   localparam logic REQ_GOTO       = 1'b1;

   // display controller constants
   localparam logic [7:0] PAGE_CMD_BASE    = 8'hB8;
   localparam logic [6:0] COLUMN_RESET     = 7'h41;
   localparam logic [6:0] RIGHT_HALF_START = 7'h40;
   localparam logic [6:0] LEFT_HALF_START  = 7'h41;
   localparam logic [7:0] LEFT_HALF_END    = 8'h80;
   localparam logic [7:0] RIGHT_HALF_END   = 8'h7F;
   localparam logic [7:0] LEFT_COLUMN_BASE = 8'd59;
   localparam logic [7:0] RIGHT_COLUMN_SUB = 8'd5;
   localparam logic [7:0] FIRST_PRINTABLE  = 8'd32;
   localparam logic [7:0] LAST_PRINTABLE   = 8'd127;
   localparam logic [4:0] LAST_LEFT_COLUMN = 5'd11;
   localparam logic [4:0] MAX_TEXT_COLUMN  = 5'd21;
   localparam logic [3:0] MAX_TEXT_LINE    = 4'd8;
   localparam logic [3:0] FIRST_LOW_LINE   = 4'd5;
   localparam logic [2:0] LAST_DATA_INDEX  = 3'd5;

   localparam int QUEUE_DEPTH = 2;
   localparam int GLYPH_COUNT = 96;

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_code;
      logic [3:0] text_line;
      logic [4:0] text_column;
   } req_item_type;

   typedef struct packed {
      logic       sel_left;
      logic       sel_right;
      logic       is_command;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_item_type;

   // one classified job for the back end
   typedef struct packed {
      logic        is_goto;
      logic [39:0] glyph;
      logic [2:0]  page;
      logic [6:0]  column;
      logic        on_left;
      logic        shift_down;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type entry;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type entry;
   } head_type;

   // 5x7 font, codes 32..127; first column in the top byte
   localparam logic [39:0] FONT_GLYPHS [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0070707000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0301710907,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h41417F4141, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0618607F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h085454543C,
      40'h7F08040478, 40'h00487D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h0C1212147E, 40'h7C08040408, 40'h4854545424,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0041360800,
      40'h00007F0000, 40'h0008364100, 40'h0804081008, 40'h1F247C241F
   };

endpackage

### rtl/core/glcd_text_cursor_writer.sv
// From req, a character goes through the queue and the output register to rsp.
// Throughput: a character takes 8 bus writes, 10 when it crosses a half, one per cycle
//    while rsp is not stalled, paced by the back end sequencer; a goto writes nothing.
// Dropped items (bad goto, unprintable code) are taken on req but never queued.
// Reset (synchronous, active high) empties the queue and sets the cursor to the left
//    half, page 0, column 0x41, no shift.
module glcd_text_cursor_writer #(
   parameter int QUEUE_DEPTH = gtcw_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gtcw_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gtcw_pkg::rsp_item_type rsp_data
);

   gtcw_pkg::push_type push;
   gtcw_pkg::head_type head;
   logic               queue_full;
   logic               pop;

   // Front end: check goto ranges and printable codes, drop the rest, look up the
   // glyph and work out the target page, half and column before queueing.
   gtcw_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push_out   (push)
   );

   // Short queue between the two ends, so the front keeps taking transfers while
   // the back is busy emitting a character.
   gtcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (queue_full),
      .head    (head)
   );

   // Back end: hold the cursor, apply gotos, and sequence page, column, font and
   // blank writes into the output register; resend the address on each half change.
   gtcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/gtcw_front.sv
module gtcw_front (
   input  logic                  req_valid,
   input  gtcw_pkg::req_item_type req_data,
   input  logic                  queue_full,
   output logic                  req_stall,
   output gtcw_pkg::push_type    push_out
);

   logic       line_ok;
   logic       column_ok;
   logic       printable;
   logic       keep;
   logic [7:0] times_six;
   logic [7:0] left_column;
   logic [7:0] right_column;
   logic [7:0] glyph_offset;

   assign req_stall = queue_full;

   always_comb begin
      line_ok   = req_data.text_line inside {[4'd1:gtcw_pkg::MAX_TEXT_LINE]};
      column_ok = req_data.text_column inside {[5'd1:gtcw_pkg::MAX_TEXT_COLUMN]};
      printable = req_data.char_code inside
                  {[gtcw_pkg::FIRST_PRINTABLE:gtcw_pkg::LAST_PRINTABLE]};
      keep = (req_data.req_type == gtcw_pkg::REQ_GOTO) ? (line_ok && column_ok) : printable;

      times_six    = ({3'b000, req_data.text_column} << 2)
                   + ({3'b000, req_data.text_column} << 1);
      left_column  = times_six + gtcw_pkg::LEFT_COLUMN_BASE;
      right_column = times_six - gtcw_pkg::RIGHT_COLUMN_SUB;
      glyph_offset = req_data.char_code - gtcw_pkg::FIRST_PRINTABLE;

      push_out.push             = req_valid && !queue_full && keep;
      push_out.entry.is_goto    = (req_data.req_type == gtcw_pkg::REQ_GOTO);
      push_out.entry.glyph      = gtcw_pkg::FONT_GLYPHS[glyph_offset[6:0]];
      push_out.entry.page       = 3'(req_data.text_line - 4'd1);
      push_out.entry.on_left    = (req_data.text_column <= gtcw_pkg::LAST_LEFT_COLUMN);
      push_out.entry.column     = push_out.entry.on_left ? left_column[6:0]
                                                         : right_column[6:0];
      push_out.entry.shift_down = (req_data.text_line >= gtcw_pkg::FIRST_LOW_LINE);
   end

endmodule

### rtl/core/gtcw_queue.sv
module gtcw_queue #(
   parameter int DEPTH = gtcw_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  gtcw_pkg::push_type push_in,
   input  logic               pop,
   output logic               full,
   output gtcw_pkg::head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gtcw_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = ptr + PTR_W'(1);
      end
   endfunction

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head.valid = (count_ff != '0);
      head.entry = entries_ff[rd_ptr_ff];
      wr_ptr_in  = push_in.push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff + CNT_W'(push_in.push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entries_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

### rtl/core/gtcw_back.sv
module gtcw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  gtcw_pkg::head_type     head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gtcw_pkg::rsp_item_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PAGE = 4'b0010,
      S_COL  = 4'b0100,
      S_DATA = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [6:0]             column_ff, column_in;
   logic                   left_ff, left_in;
   logic [2:0]             page_ff, page_in;
   logic                   shift_ff, shift_in;
   logic [39:0]            glyph_ff, glyph_in;
   logic [2:0]             idx_ff, idx_in;
   logic                   final_ff, final_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gtcw_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic                   out_free;
   logic                   emit;
   gtcw_pkg::rsp_item_type emit_item;
   logic [7:0]             next_col;
   logic                   adv_switch;
   logic [6:0]             adv_column;
   logic                   adv_left;
   logic [7:0]             data_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;

      // column advance after a data byte, with half change
      next_col   = {1'b0, column_ff} + 8'd1;
      adv_switch = 1'b0;
      adv_left   = left_ff;
      adv_column = next_col[6:0];
      if (left_ff && next_col == gtcw_pkg::LEFT_HALF_END) begin
         adv_switch = 1'b1;
         adv_left   = 1'b0;
         adv_column = gtcw_pkg::RIGHT_HALF_START;
      end else if (!left_ff && next_col == gtcw_pkg::RIGHT_HALF_END) begin
         adv_switch = 1'b1;
         adv_left   = 1'b1;
         adv_column = gtcw_pkg::LEFT_HALF_START;
      end

      data_byte = shift_ff ? {glyph_ff[38:32], 1'b0} : glyph_ff[39:32];

      state_in  = state_ff;
      column_in = column_ff;
      left_in   = left_ff;
      page_in   = page_ff;
      shift_in  = shift_ff;
      glyph_in  = glyph_ff;
      idx_in    = idx_ff;
      final_in  = final_ff;
      pop       = 1'b0;
      emit      = 1'b0;

      emit_item.sel_left   = left_ff;
      emit_item.sel_right  = !left_ff;
      emit_item.is_command = 1'b1;
      emit_item.bus_byte   = gtcw_pkg::PAGE_CMD_BASE + {5'b00000, page_ff};
      emit_item.last       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.is_goto) begin
                  column_in = head.entry.column;
                  left_in   = head.entry.on_left;
                  page_in   = head.entry.page;
                  shift_in  = head.entry.shift_down;
               end else begin
                  glyph_in = head.entry.glyph;
                  idx_in   = '0;
                  final_in = 1'b0;
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = S_COL;
                  end else begin
                     state_in = S_PAGE;
                  end
               end
            end
         end
         S_PAGE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_COL;
            end
         end
         S_COL: begin
            emit_item.bus_byte = {1'b0, column_ff};
            emit_item.last     = final_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = final_ff ? S_IDLE : S_DATA;
            end
         end
         S_DATA: begin
            emit_item.is_command = 1'b0;
            emit_item.bus_byte   = data_byte;
            emit_item.last       = (idx_ff == gtcw_pkg::LAST_DATA_INDEX) && !adv_switch;
            if (out_free) begin
               emit      = 1'b1;
               glyph_in  = {glyph_ff[31:0], 8'h00};
               idx_in    = idx_ff + 3'd1;
               column_in = adv_column;
               left_in   = adv_left;
               if (adv_switch) begin
                  final_in = (idx_ff == gtcw_pkg::LAST_DATA_INDEX);
                  state_in = S_PAGE;
               end else if (idx_ff == gtcw_pkg::LAST_DATA_INDEX) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_data_in  = emit_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         column_ff    <= gtcw_pkg::COLUMN_RESET;
         left_ff      <= 1'b1;
         page_ff      <= '0;
         shift_ff     <= 1'b0;
         idx_ff       <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         column_ff    <= column_in;
         left_ff      <= left_in;
         page_ff      <= page_in;
         shift_ff     <= shift_in;
         idx_ff       <= idx_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_data_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DATA |-> idx_ff <= gtcw_pkg::LAST_DATA_INDEX)
      else $error("data byte index past the blank byte");

   a_right_half_column: assert property (@(posedge clock) disable iff (reset)
      !left_ff |-> (column_ff >= gtcw_pkg::RIGHT_HALF_START && column_ff <= 7'h7E))
      else $error("right half column outside its window");

   a_blank_byte: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DATA && out_free && idx_ff == gtcw_pkg::LAST_DATA_INDEX
      |=> rsp_valid_ff && rsp_data_ff.bus_byte == 8'h00 && !rsp_data_ff.is_command)
      else $error("closing data byte of a character is not blank");

endmodule

### test/glcd_text_check_pkg.sv
package glcd_text_check_pkg;

   import gtcw_pkg::*;

   // 5x7 font, five columns per glyph for codes 32..127, bit 0 on top
   localparam logic [7:0] GLYPH_COLUMNS [480] = '{
      0,0,0,0,0, 0,0,95,0,0, 0,7,0,7,0, 20,127,20,127,20,
      36,42,127,42,18, 35,19,8,100,98, 54,73,85,34,80, 0,5,3,0,0,
      0,28,34,65,0, 0,65,34,28,0, 20,8,62,8,20, 8,8,62,8,8,
      0,80,48,0,0, 8,8,8,8,8, 0,112,112,112,0, 32,16,8,4,2,
      62,81,73,69,62, 0,66,127,64,0, 66,97,81,73,70, 33,65,69,75,49,
      24,20,18,127,16, 39,69,69,69,57, 60,74,73,73,48, 3,1,113,9,7,
      54,73,73,73,54, 6,73,73,41,30, 0,54,54,0,0, 0,86,54,0,0,
      8,20,34,65,0, 20,20,20,20,20, 65,34,20,8,0, 2,1,81,9,6,
      50,73,121,65,62, 126,17,17,17,126, 127,73,73,73,54, 62,65,65,65,34,
      127,65,65,65,62, 127,73,73,73,65, 127,9,9,9,1, 62,65,73,73,122,
      127,8,8,8,127, 65,65,127,65,65, 32,64,65,63,1, 127,8,20,34,65,
      127,64,64,64,64, 127,2,12,2,127, 127,6,24,96,127, 62,65,65,65,62,
      127,9,9,9,6, 62,65,81,33,94, 127,9,25,41,70, 70,73,73,73,49,
      1,1,127,1,1, 63,64,64,64,63, 31,32,64,32,31, 63,64,56,64,63,
      99,20,8,20,99, 7,8,112,8,7, 97,81,73,69,67, 0,127,65,65,0,
      2,4,8,16,32, 0,65,65,127,0, 4,2,1,2,4, 64,64,64,64,64,
      0,1,2,4,0, 32,84,84,84,120, 127,72,68,68,56, 56,68,68,68,32,
      56,68,68,72,127, 56,84,84,84,24, 8,126,9,1,2, 8,84,84,84,60,
      127,8,4,4,120, 0,72,125,64,0, 32,64,68,61,0, 127,16,40,68,0,
      0,65,127,64,0, 124,4,24,4,120, 124,8,4,4,120, 56,68,68,68,56,
      124,20,20,20,8, 12,18,18,20,126, 124,8,4,4,8, 72,84,84,84,36,
      4,63,68,64,32, 60,64,64,32,124, 28,32,64,32,28, 60,64,48,64,60,
      68,40,16,40,68, 12,80,80,80,60, 68,100,84,76,68, 0,65,54,8,0,
      0,0,127,0,0, 0,8,54,65,0, 8,4,8,16,8, 31,36,124,36,31
   };

   class bus_write_tracker;
      rsp_item_type pending_writes[$];
      int unsigned  mismatches;
      int unsigned  writes_seen;
      logic [6:0]   column;
      logic         left_half;
      logic [2:0]   page;
      logic         shift;

      function new();
         column    = 7'h41;
         left_half = 1'b1;
         page      = 3'd0;
         shift     = 1'b0;
      endfunction

      function void push_write(logic is_cmd, logic [7:0] value);
         rsp_item_type w;
         w.sel_left   = left_half;
         w.sel_right  = !left_half;
         w.is_command = is_cmd;
         w.bus_byte   = value;
         w.last       = 1'b0;
         pending_writes.push_back(w);
      endfunction

      function void push_address();
         push_write(1'b1, 8'hB8 + {5'd0, page});
         push_write(1'b1, {1'b0, column});
      endfunction

      // advance one column; a half change resends page and column
      function void step_column();
         logic [7:0] next;
         next = {1'b0, column} + 8'd1;
         if (left_half && next == 8'h80) begin
            column    = 7'h40;
            left_half = 1'b0;
            push_address();
         end else begin
            column = next[6:0];
            if (!left_half && next == 8'h7F) begin
               column    = 7'h41;
               left_half = 1'b1;
               push_address();
            end
         end
      endfunction

      function void note_request(req_item_type req);
         logic [7:0]   glyph_byte;
         int unsigned  base;
         rsp_item_type tail;
         if (req.req_type == REQ_GOTO) begin
            if (req.text_line < 4'd1 || req.text_line > 4'd8 ||
                req.text_column < 5'd1 || req.text_column > 5'd21)
               return;
            shift = (req.text_line >= 4'd5);
            page  = 3'(req.text_line - 4'd1);
            if (req.text_column < 5'd12) begin
               column    = 7'(59 + 6 * int'(req.text_column));
               left_half = 1'b1;
            end else begin
               column    = 7'(6 * int'(req.text_column) - 5);
               left_half = 1'b0;
            end
            return;
         end
         if (req.char_code < 8'd32 || req.char_code > 8'd127)
            return;
         base = (int'(req.char_code) - 32) * 5;
         push_address();
         for (int k = 0; k < 5; k++) begin
            glyph_byte = GLYPH_COLUMNS[base + k];
            if (shift)
               glyph_byte = glyph_byte << 1;
            push_write(1'b0, glyph_byte);
            step_column();
         end
         push_write(1'b0, 8'h00);
         step_column();
         tail = pending_writes.pop_back();
         tail.last = 1'b1;
         pending_writes.push_back(tail);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40)
            $display("MISMATCH write %0d: %s", writes_seen, what);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         writes_seen++;
         if (pending_writes.size() == 0) begin
            report($sformatf("unexpected write %h", got));
            return;
         end
         want = pending_writes.pop_front();
         if (got.sel_left !== want.sel_left)
            report($sformatf("sel_left %b, want %b", got.sel_left, want.sel_left));
         if (got.sel_right !== want.sel_right)
            report($sformatf("sel_right %b, want %b", got.sel_right, want.sel_right));
         if (got.is_command !== want.is_command)
            report($sformatf("is_command %b, want %b", got.is_command, want.is_command));
         if (got.bus_byte !== want.bus_byte)
            report($sformatf("bus_byte %h, want %h", got.bus_byte, want.bus_byte));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

endpackage

### test/tb_glcd_text_cursor_writer.sv
module tb_glcd_text_cursor_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import gtcw_pkg::*;
   import glcd_text_check_pkg::*;

   localparam int RANDOM_ITEMS = 106;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_EVERY_THIRD,
      STALL_HEAVY
   } stall_mode_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   bus_write_tracker tracker;
   int unsigned      burst_left;
   int unsigned      idle_cycles = 0;
   stall_mode_type   stall_mode = STALL_NONE;
   int unsigned      stall_phase_left = 0;
   int unsigned      stall_tick = 0;

   glcd_text_cursor_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver side: pick a stall mode, hold it for a random stretch, then switch.
   // The quiet mode gives stretches with no back pressure at all.
   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 3));
         stall_phase_left = $urandom_range(10, 60);
      end
      stall_phase_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:        rsp_stall <= 1'b0;
         STALL_COIN:        rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_EVERY_THIRD: rsp_stall <= (stall_tick % 3 == 0);
         default:           rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Check every result transfer against the oldest predicted bus write.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_data);
   end

   // Watchdog: count cycles in which neither channel moves a transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic req_item_type make_item(logic kind, logic [7:0] code,
                                              logic [3:0] line, logic [4:0] col);
      req_item_type item;
      item.req_type    = kind;
      item.char_code   = code;
      item.text_line   = line;
      item.text_column = col;
      return item;
   endfunction

   // Drive one item at the falling edge and hold it until the transfer.
   // Between bursts drop valid for a random gap; a zero gap keeps valid high.
   task automatic send_item(input req_item_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracker.note_request(item);
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted write has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.pending_writes.size() != 0);
      burst_left = 0;
   endtask

   initial begin
      int unsigned counted;
      int unsigned pick;
      logic [7:0]  code;
      logic [3:0]  line;
      logic [4:0]  col;
      logic        kind;
      logic        paused;

      tracker          = new();
      req_valid        = 1'b0;
      req_data         = '0;
      burst_left       = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part.
      // Character straight out of reset, then both ends of the printable range.
      send_item(make_item(REQ_WRITE_CHAR, 8'd65, 4'd0, 5'd0));
      send_item(make_item(REQ_WRITE_CHAR, 8'd32, 4'd0, 5'd0));
      send_item(make_item(REQ_WRITE_CHAR, 8'd127, 4'd0, 5'd0));
      // Unprintable codes on both sides of the range: nothing comes out.
      send_item(make_item(REQ_WRITE_CHAR, 8'd31, 4'd3, 5'd4));
      send_item(make_item(REQ_WRITE_CHAR, 8'd128, 4'd3, 5'd4));
      send_item(make_item(REQ_WRITE_CHAR, 8'd0, 4'd0, 5'd0));
      send_item(make_item(REQ_WRITE_CHAR, 8'd255, 4'd15, 5'd31));
      // Out-of-range gotos must leave the cursor where it is.
      send_item(make_item(REQ_GOTO, 8'd0, 4'd0, 5'd5));
      send_item(make_item(REQ_GOTO, 8'd0, 4'd9, 5'd5));
      send_item(make_item(REQ_GOTO, 8'd255, 4'd15, 5'd31));
      send_item(make_item(REQ_GOTO, 8'd0, 4'd3, 5'd0));
      send_item(make_item(REQ_GOTO, 8'd0, 4'd3, 5'd22));
      send_item(make_item(REQ_WRITE_CHAR, 8'd72, 4'd0, 5'd0));
      // Corners of the text grid.
      send_item(make_item(REQ_GOTO, 8'd0, 4'd1, 5'd1));
      send_item(make_item(REQ_WRITE_CHAR, 8'd35, 4'd0, 5'd0));
      // Bottom right, shifted font, crosses from the right half back to the left.
      send_item(make_item(REQ_GOTO, 8'd0, 4'd8, 5'd21));
      send_item(make_item(REQ_WRITE_CHAR, 8'd87, 4'd0, 5'd0));
      send_item(make_item(REQ_WRITE_CHAR, 8'd64, 4'd0, 5'd0));
      // Last left column: the glyph runs off the left half.
      send_item(make_item(REQ_GOTO, 8'd0, 4'd4, 5'd11));
      send_item(make_item(REQ_WRITE_CHAR, 8'd77, 4'd0, 5'd0));
      // First right column on the first shifted line.
      send_item(make_item(REQ_GOTO, 8'd0, 4'd5, 5'd12));
      send_item(make_item(REQ_WRITE_CHAR, 8'd126, 4'd0, 5'd0));
      // Unused fields set to all ones must not matter.
      send_item(make_item(REQ_GOTO, 8'd255, 4'd4, 5'd1));
      send_item(make_item(REQ_WRITE_CHAR, 8'd90, 4'd15, 5'd31));

      // Random part: mostly printable characters and valid gotos with noise in
      // the unused fields, with some dropped items mixed in.
      counted = 0;
      paused  = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         code = 8'($urandom);
         line = 4'($urandom);
         col  = 5'($urandom);
         if (pick < 62) begin
            kind = REQ_WRITE_CHAR;
            code = 8'($urandom_range(32, 127));
         end else if (pick < 80) begin
            kind = REQ_GOTO;
            line = 4'($urandom_range(1, 8));
            col  = 5'($urandom_range(1, 21));
         end else if (pick < 90) begin
            kind = REQ_GOTO;
            if ($urandom_range(0, 1) == 0)
               line = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            else
               col = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(22, 31));
         end else begin
            kind = REQ_WRITE_CHAR;
            code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(128, 255));
         end
         send_item(make_item(kind, code, line, col));
         counted++;
         // Once, halfway through, let the block run dry before going on.
         if (!paused && counted >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            wait_for_drain();
         end
      end

      // Drop valid, wait for the last writes, then leave room for strays.
      req_valid <= 1'b0;
      while (tracker.pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
rtl/core/gtcw_pkg.sv
rtl/core/gtcw_front.sv
rtl/core/gtcw_queue.sv
rtl/core/gtcw_back.sv
rtl/core/glcd_text_cursor_writer.sv
test/glcd_text_check_pkg.sv
test/tb_glcd_text_cursor_writer.sv
